@@ rtl/jet_pkg.sv @@
// shared types and constants for the julia escape-time block
`timescale 1ns / 1ps
package jet_pkg;
  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_CENTER_RE = 3'd0;
  localparam logic [2:0] REG_CENTER_IM = 3'd1;
  localparam logic [2:0] REG_PLANE_W   = 3'd2;
  localparam logic [2:0] REG_PLANE_H   = 3'd3;
  localparam logic [2:0] REG_COLS      = 3'd4;
  localparam logic [2:0] REG_ROWS      = 3'd5;
  localparam logic [2:0] REG_SEED_RE   = 3'd6;
  localparam logic [2:0] REG_SEED_IM   = 3'd7;

  // one divider cell's running state
  typedef struct packed {
    logic        neg;
    logic [44:0] rem;
    logic [44:0] quo;
  } div_slot_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction
endpackage

@@ rtl/jet_if.sv @@
// valid/ready channel interfaces for pixel requests and counts
`timescale 1ns / 1ps
interface jet_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface jet_cnt_if;
  logic       valid;
  logic       ready;
  logic [7:0] escape_count;
  modport source (output valid, escape_count, input ready);
  modport sink (input valid, escape_count, output ready);
endinterface

@@ rtl/jet_div_cell.sv @@
// one restoring-division cell: takes a slot, produces one quotient bit
`timescale 1ns / 1ps
module jet_div_cell (
  input  logic                    clk,
  input  logic [27:0]             divisor,
  input  jet_pkg::div_slot_t      slot_in,
  input  logic                    num_bit,
  output jet_pkg::div_slot_t      slot_out
);
  import jet_pkg::*;
  div_slot_t  slot_r;
  logic [45:0] trial;
  logic [44:0] shifted;

  always_comb begin
    shifted = {slot_in.rem[43:0], num_bit};
    trial   = {1'b0, shifted} - {18'd0, divisor};
  end

  always_ff @(posedge clk) begin
    slot_r.neg <= slot_in.neg;
    slot_r.quo <= {slot_in.quo[43:0], ~trial[45]};
    slot_r.rem <= trial[45] ? shifted : trial[44:0];
  end

  assign slot_out = slot_r;
endmodule

@@ rtl/jet_iter.sv @@
// shared complex square-add unit with escape test
`timescale 1ns / 1ps
module jet_iter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] z_re,
  input  logic signed [31:0] z_im,
  input  logic signed [31:0] c_re,
  input  logic signed [31:0] c_im,
  input  logic [15:0]        max_iter,
  output logic               done,
  output logic [7:0]         count
);
  import jet_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  // |z|^2 limit of 4 at the full product scale, 2^58
  localparam logic [64:0] ESC_BOUND = 65'h0400_0000_0000_0000;

  logic [1:0]  state_r, state_nxt;
  logic signed [31:0] re_r, im_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic [15:0] k_r;
  logic        done_r;
  logic [64:0] mag;
  logic signed [65:0] dr, di;
  logic signed [31:0] nr, ni;

  always_comb begin
    mag = {1'b0, rr_r} + {1'b0, ii_r};
    dr  = ($signed({{2{rr_r[63]}}, rr_r}) - $signed({{2{ii_r[63]}}, ii_r})) >>> 28;
    di  = $signed({{2{ri_r[63]}}, ri_r}) >>> 27;
    nr  = sat32(66'(sat32(dr)) + 66'(c_re));
    ni  = sat32(66'(sat32(di)) + 66'(c_im));
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_MUL;
      S_MUL:  state_nxt = (k_r >= max_iter) ? S_IDLE : S_ADD;
      S_ADD:  state_nxt = (mag > ESC_BOUND) ? S_IDLE : S_MUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          re_r <= z_re;
          im_r <= z_im;
          k_r  <= '0;
        end
        S_MUL: begin
          rr_r <= re_r * re_r;
          ii_r <= im_r * im_r;
          ri_r <= re_r * im_r;
          if (k_r >= max_iter) done_r <= 1'b1;
        end
        S_ADD: begin
          if (mag > ESC_BOUND) done_r <= 1'b1;
          else begin
            re_r <= nr;
            im_r <= ni;
            k_r  <= k_r + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign done  = done_r;
  assign count = (k_r > 16'd255) ? 8'd255 : k_r[7:0];
endmodule

@@ rtl/julia_escape_time.sv @@
// julia set escape-time block top level
// Usage: write configuration over the cfg_ APB port while idle (8 registers
// at 4-byte spacing, reads return the stored value). Send one pixel request
// on in_ (valid/ready); one 8-bit escape count comes back on out_.
// The pixel centre is mapped by two chains of 45 divider cells
// (one quotient bit per cell per cycle), then the shared complex
// multiply-add unit runs a multiply state and an add state per
// iteration, up to MAX_ITER iterations.
// One request is in flight at a time; in_ready is low while it works.
// The count is held in an output register until out_ready; if the
// receiver stalls, the block waits and accepts no new request.
// Reset (rst_n, synchronous, low) restores the default view and clears
// all control state.
`timescale 1ns / 1ps
module julia_escape_time #(
  parameter int MAX_ITER = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  jet_pix_if.sink     in_ch,
  jet_cnt_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [jet_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jet_pkg::*;
  localparam int NCELL = 45;
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_DIV  = 2'd1;
  localparam logic [1:0] T_ITER = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [31:0] cre_r, cim_r, sre_r, sim_r;
  logic [30:0] pw_r, ph_r;
  logic [12:0] cols_r, rows_r;
  logic [1:0]  state_r;
  logic [5:0]  cnt_r;
  logic [7:0]  res_r;
  logic [2:0]  widx;
  logic [12:0] cols_c, rows_c;
  logic signed [45:0] num_x, num_y;
  logic [44:0] ax_r, ay_r;
  logic        nx_r, ny_r;
  logic [27:0] dx_r, dy_r;
  div_slot_t   sx [NCELL+1];
  div_slot_t   sy [NCELL+1];
  logic signed [46:0] qx, qy;
  logic        it_start, it_done;
  logic [7:0]  it_cnt;

  assign widx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    case (widx)
      REG_CENTER_RE: cfg_prdata = cre_r;
      REG_CENTER_IM: cfg_prdata = cim_r;
      REG_PLANE_W:   cfg_prdata = {1'b0, pw_r};
      REG_PLANE_H:   cfg_prdata = {1'b0, ph_r};
      REG_COLS:      cfg_prdata = {19'd0, cols_r};
      REG_ROWS:      cfg_prdata = {19'd0, rows_r};
      REG_SEED_RE:   cfg_prdata = sre_r;
      REG_SEED_IM:   cfg_prdata = sim_r;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cre_r <= '0; cim_r <= '0;
      pw_r <= 31'd1073741824; ph_r <= 31'd1073741824;
      cols_r <= 13'd640; rows_r <= 13'd480;
      sre_r <= 32'd76504268; sim_r <= 32'd2684355;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_CENTER_RE: cre_r <= cfg_pwdata;
        REG_CENTER_IM: cim_r <= cfg_pwdata;
        REG_PLANE_W:   pw_r <= cfg_pwdata[30:0];
        REG_PLANE_H:   ph_r <= cfg_pwdata[30:0];
        REG_COLS:      cols_r <= cfg_pwdata[12:0];
        REG_ROWS:      rows_r <= cfg_pwdata[12:0];
        REG_SEED_RE:   sre_r <= cfg_pwdata;
        REG_SEED_IM:   sim_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // clamp resolution to 1..4096
  always_comb begin
    cols_c = (cols_r == 13'd0) ? 13'd1 : (cols_r > 13'd4096) ? 13'd4096 : cols_r;
    rows_c = (rows_r == 13'd0) ? 13'd1 : (rows_r > 13'd4096) ? 13'd4096 : rows_r;
    num_x = $signed({1'b0, 45'({in_ch.pixel_col, 1'b1}) * 45'(pw_r)})
          - $signed({1'b0, 45'(cols_c) * 45'(pw_r)});
    num_y = $signed({1'b0, 45'(rows_c) * 45'(ph_r)})
          - $signed({1'b0, 45'({in_ch.pixel_row, 1'b1}) * 45'(ph_r)});
  end

  // floor division via magnitude: negatives use (|n| + d - 1) / d
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      nx_r <= num_x[45];
      ny_r <= num_y[45];
      dx_r <= {14'd0, cols_c, 1'b0};
      dy_r <= {14'd0, rows_c, 1'b0};
      ax_r <= num_x[45] ? 45'(-num_x + 46'({cols_c, 1'b0}) - 46'd1) : num_x[44:0];
      ay_r <= num_y[45] ? 45'(-num_y + 46'({rows_c, 1'b0}) - 46'd1) : num_y[44:0];
    end
  end

  assign sx[0] = '{neg: nx_r, rem: '0, quo: '0};
  assign sy[0] = '{neg: ny_r, rem: '0, quo: '0};

  // each cell consumes one dividend bit, msb first, following the wavefront
  for (genvar g = 0; g < NCELL; g++) begin : g_div
    jet_div_cell u_x (.clk(clk), .divisor(dx_r), .slot_in(sx[g]),
                      .num_bit(ax_r[NCELL-1-g]), .slot_out(sx[g+1]));
    jet_div_cell u_y (.clk(clk), .divisor(dy_r), .slot_in(sy[g]),
                      .num_bit(ay_r[NCELL-1-g]), .slot_out(sy[g+1]));
  end

  always_comb begin
    qx = sx[NCELL].neg ? -$signed({2'b0, sx[NCELL].quo}) : $signed({2'b0, sx[NCELL].quo});
    qy = sy[NCELL].neg ? -$signed({2'b0, sy[NCELL].quo}) : $signed({2'b0, sy[NCELL].quo});
  end

  assign it_start = (state_r == T_DIV) && (cnt_r == 6'(NCELL));

  jet_iter u_iter (
    .clk(clk), .rst_n(rst_n), .start(it_start),
    .z_re(sat32(66'(qx) + 66'($signed(cre_r)))),
    .z_im(sat32(66'(qy) + 66'($signed(cim_r)))),
    .c_re(sre_r), .c_im(sim_r),
    .max_iter(16'(MAX_ITER)),
    .done(it_done), .count(it_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        T_IDLE: if (in_ch.valid) begin
          state_r <= T_DIV;
          cnt_r   <= '0;
        end
        T_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (it_start) state_r <= T_ITER;
        end
        T_ITER: if (it_done) begin
          res_r   <= it_cnt;
          state_r <= T_OUT;
        end
        T_OUT: if (out_ch.ready) state_r <= T_IDLE;
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == T_IDLE);
  assign out_ch.valid = (state_r == T_OUT);
  assign out_ch.escape_count = res_r;
endmodule
